// File: rtl/rtr_pkg.sv
// Shared types, widths and codes of the receive timestamp ring.
package rtr_pkg;

	localparam int RING_DEPTH = 256;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int ACT_W  = 2;
	localparam int PN_W   = 62;
	localparam int TIME_W = 63;
	localparam int US_W   = 54;

	localparam int DIVISOR   = 1000;
	localparam int REM_W     = $clog2(DIVISOR);
	localparam int DIG_W     = 16;
	localparam int DIGITS    = 4;
	localparam int DVD_W     = DIG_W * DIGITS;
	localparam int VAL_W     = REM_W + DIG_W;
	localparam int RECIP_SH  = 36;
	localparam int RECIP_W   = 27;
	localparam int PROD_W    = VAL_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
	localparam int DIV_CNT_W = $clog2(DIGITS);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

	localparam logic [ACT_W-1:0] ACT_RECORD    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_LOOKUP    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd2;
	localparam logic [ACT_W-1:0] ACT_SET_BASIS = 2'd3;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [PN_W-1:0]   pn_t;
	typedef logic [TIME_W-1:0] time_ns_t;
	typedef logic [US_W-1:0]   time_us_t;

	typedef struct packed {
		pn_t      pn;
		time_us_t us;
	} entry_t;

	typedef struct packed {
		logic ld_item;
		logic rec_prep;
		logic rec_write;
		logic scan_start;
		logic scan_step;
		logic res_hit;
		logic res_zero;
		logic ring_clear;
		logic basis_load;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic    div_busy;
		logic    scan_hit;
		logic    scan_end;
		logic    out_free;
		action_t act;
	} dp_sts_t;

endpackage

// File: rtl/rtr_item_if.sv
// Input channel: valid/ready handshake carrying one ring action.
interface rtr_item_if;
	logic                valid;
	logic                ready;
	rtr_pkg::action_t    action;
	rtr_pkg::pn_t        packet_number;
	rtr_pkg::time_ns_t   time_ns;

	modport source (output valid, action, packet_number, time_ns, input ready);
	modport sink (input valid, action, packet_number, time_ns, output ready);
endinterface

// File: rtl/rtr_result_if.sv
// Result channel: valid/ready handshake carrying one ring result.
interface rtr_result_if;
	logic              valid;
	logic              ready;
	logic              found;
	rtr_pkg::time_us_t time_us;

	modport source (output valid, found, time_us, input ready);
	modport sink (input valid, found, time_us, output ready);
endinterface

// File: rtl/rtr_div.sv
// Divider by the constant microsecond divisor: four 16-bit digits, reciprocal multiply per digit.
module rtr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  rtr_pkg::time_ns_t dividend,
	output logic              busy,
	output rtr_pkg::time_us_t quotient
);

	logic                            busy_q;
	logic                            phase_q;
	logic [rtr_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [rtr_pkg::DVD_W-1:0]       dvd_q;
	logic [rtr_pkg::REM_W-1:0]       rem_q;
	logic [rtr_pkg::DIG_W-1:0]       qd_q;
	rtr_pkg::time_us_t               quot_q;
	logic [rtr_pkg::VAL_W-1:0]       val;
	logic [rtr_pkg::PROD_W-1:0]      prod;
	logic [rtr_pkg::VAL_W-1:0]       back;

	// partial remainder joined with the next digit; digit quotient by reciprocal
	assign val  = {rem_q, dvd_q[rtr_pkg::DVD_W-1 -: rtr_pkg::DIG_W]};
	assign prod = rtr_pkg::PROD_W'(val) * rtr_pkg::PROD_W'(rtr_pkg::RECIP);
	assign back = rtr_pkg::VAL_W'(qd_q) * rtr_pkg::VAL_W'(rtr_pkg::DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			phase_q <= 1'b0;
			cnt_q   <= rtr_pkg::DIV_CNT_W'(rtr_pkg::DIGITS - 1);
		end else if (busy_q) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= rtr_pkg::DVD_W'(dividend);
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				qd_q <= prod[rtr_pkg::RECIP_SH +: rtr_pkg::DIG_W];
			end else begin
				dvd_q  <= {dvd_q[rtr_pkg::DVD_W-rtr_pkg::DIG_W-1:0], {rtr_pkg::DIG_W{1'b0}}};
				rem_q  <= rtr_pkg::REM_W'(val - back);
				quot_q <= {quot_q[rtr_pkg::US_W-rtr_pkg::DIG_W-1:0], qd_q};
			end
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

// File: rtl/rtr_dp.sv
// Datapath: item latch, time basis, ring memory, scan pointer and result register.
module rtr_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  rtr_pkg::dp_cmd_t  cmd,
	output rtr_pkg::dp_sts_t  sts,
	input  rtr_pkg::action_t  item_action,
	input  rtr_pkg::pn_t      item_pn,
	input  rtr_pkg::time_ns_t item_time,
	input  logic              out_ready,
	output logic              out_valid,
	output logic              out_found,
	output rtr_pkg::time_us_t out_us
);

	rtr_pkg::action_t            act_q;
	rtr_pkg::pn_t                pn_q;
	rtr_pkg::time_ns_t           t_q;
	rtr_pkg::time_ns_t           basis_q;
	logic                        basis_set_q;
	logic [rtr_pkg::IDX_W-1:0]   head_q;
	logic [rtr_pkg::CNT_W-1:0]   fill_q;
	rtr_pkg::entry_t             mem_q [rtr_pkg::RING_DEPTH];
	logic [rtr_pkg::IDX_W-1:0]   addr_q;
	logic [rtr_pkg::CNT_W-1:0]   remain_q;
	logic                        rd_pend_s1;
	rtr_pkg::entry_t             rdata_s1;
	logic                        res_found_q;
	rtr_pkg::time_us_t           res_us_q;
	logic                        out_valid_q;
	logic                        out_found_q;
	rtr_pkg::time_us_t           out_us_q;

	rtr_pkg::time_ns_t           eff_basis;
	rtr_pkg::time_ns_t           diff;
	logic                        div_busy;
	rtr_pkg::time_us_t           quot;
	rtr_pkg::entry_t             wr_entry;

	assign eff_basis = basis_set_q ? basis_q : t_q;
	assign diff      = (t_q >= eff_basis) ? t_q - eff_basis : '0;
	assign wr_entry  = '{pn: pn_q, us: quot};

	rtr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rec_prep),
		.dividend (diff),
		.busy     (div_busy),
		.quotient (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.ld_item) begin
			act_q <= item_action;
			pn_q  <= item_pn;
			t_q   <= item_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_q     <= '0;
			basis_set_q <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
		end else if (cmd.ring_clear) begin
			basis_q     <= '0;
			basis_set_q <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (cmd.basis_load || (cmd.rec_prep && !basis_set_q)) begin
				basis_q     <= t_q;
				basis_set_q <= 1'b1;
			end
			if (cmd.rec_write) begin
				head_q <= (head_q == rtr_pkg::LAST_IDX) ? '0 : head_q + 1'b1;
				if (fill_q != rtr_pkg::FULL_CNT) begin
					fill_q <= fill_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_write) begin
			mem_q[head_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && remain_q != '0) begin
			rdata_s1 <= mem_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			remain_q   <= '0;
			rd_pend_s1 <= 1'b0;
		end else if (cmd.scan_start) begin
			addr_q     <= (head_q == '0) ? rtr_pkg::LAST_IDX : head_q - 1'b1;
			remain_q   <= fill_q;
			rd_pend_s1 <= 1'b0;
		end else if (cmd.scan_step) begin
			if (remain_q != '0) begin
				addr_q     <= (addr_q == '0) ? rtr_pkg::LAST_IDX : addr_q - 1'b1;
				remain_q   <= remain_q - 1'b1;
				rd_pend_s1 <= 1'b1;
			end else begin
				rd_pend_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_write) begin
			res_found_q <= 1'b1;
			res_us_q    <= quot;
		end else if (cmd.res_hit) begin
			res_found_q <= 1'b1;
			res_us_q    <= rdata_s1.us;
		end else if (cmd.res_zero) begin
			res_found_q <= 1'b0;
			res_us_q    <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_found_q <= res_found_q;
			out_us_q    <= res_us_q;
		end
	end

	assign sts.div_busy = div_busy;
	assign sts.scan_hit = rd_pend_s1 && (rdata_s1.pn == pn_q);
	assign sts.scan_end = !rd_pend_s1 && (remain_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.act      = act_q;

	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_us    = out_us_q;

endmodule

// File: rtl/rtr_ctrl.sv
// Controller: sequences record, lookup scan, clear and basis load for one beat at a time.
module rtr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  rtr_pkg::action_t  item_action,
	output logic              item_ready,
	input  rtr_pkg::dp_sts_t  sts,
	output rtr_pkg::dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_REC_PREP = 3'd1;
	localparam logic [2:0] S_REC_DIV  = 3'd2;
	localparam logic [2:0] S_LK_START = 3'd3;
	localparam logic [2:0] S_LK_SCAN  = 3'd4;
	localparam logic [2:0] S_MISC     = 3'd5;
	localparam logic [2:0] S_RESULT   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.ld_item = 1'b1;
					case (item_action)
						rtr_pkg::ACT_RECORD: state_d = S_REC_PREP;
						rtr_pkg::ACT_LOOKUP: state_d = S_LK_START;
						default:             state_d = S_MISC;
					endcase
				end
			end
			S_REC_PREP: begin
				cmd.rec_prep = 1'b1;
				state_d      = S_REC_DIV;
			end
			S_REC_DIV: begin
				if (!sts.div_busy) begin
					cmd.rec_write = 1'b1;
					state_d       = S_RESULT;
				end
			end
			S_LK_START: begin
				cmd.scan_start = 1'b1;
				state_d        = S_LK_SCAN;
			end
			S_LK_SCAN: begin
				if (sts.scan_hit) begin
					cmd.res_hit = 1'b1;
					state_d     = S_RESULT;
				end else if (sts.scan_end) begin
					cmd.res_zero = 1'b1;
					state_d      = S_RESULT;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_MISC: begin
				cmd.res_zero   = 1'b1;
				cmd.ring_clear = (sts.act == rtr_pkg::ACT_CLEAR);
				cmd.basis_load = (sts.act == rtr_pkg::ACT_SET_BASIS);
				state_d        = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

endmodule

// File: rtl/receive_timestamp_ring_core.sv
// Top level of the receive timestamp ring: controller, datapath and channel hookup.
//
//  channel  dir  beat contents
//  item     in   action, packet_number, time_ns
//  result   out  found, time_us
//
// One beat is in flight at a time; a finished result waits in the output
// register while the next beat is taken. Steps per beat, from accept until ready again:
// Record: the divide by 1000 in four 16-bit digits, each a digit quotient step, then a remainder step.
// Lookup: at worst every filled entry is read, one ring memory read per cycle.
// Clear and set basis: the misc state, then the result state. Reset empties the ring at once (fill count).
// A stalled result holds only the output register; the core stalls before reloading it.
module receive_timestamp_ring_core (
	input logic          clk,
	input logic          arst_n,
	rtr_item_if.sink     item,
	rtr_result_if.source result
);

	rtr_pkg::dp_cmd_t cmd;
	rtr_pkg::dp_sts_t sts;

	rtr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item.valid),
		.item_action (item.action),
		.item_ready  (item.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	rtr_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item_action (item.action),
		.item_pn     (item.packet_number),
		.item_time   (item.time_ns),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_found   (result.found),
		.out_us      (result.time_us)
	);

endmodule
